// ===== sv/ecpd_pkg.sv =====
// ecpd_pkg: shared types and constants for the encoder PID motor drive.
// Holds command codes, register indexes, reset values, the configuration struct and fixed widths.
// No dependencies.
package ecpd_pkg;

   // Fixed field and datapath widths
   localparam int POS_W     = 40;   // position and target, signed
   localparam int DIFF_W    = 41;   // position difference and error, signed
   localparam int VEL_W     = 48;   // velocity and integrator, signed
   localparam int CFG_W     = 16;   // every configuration register
   localparam int MUL_A_W   = 18;   // signed coefficient operand
   localparam int MUL_B_W   = 49;   // signed data operand
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int DUTY_W    = 8;
   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   // Command codes of an input item
   localparam logic [CMD_W-1:0] CMD_EDGE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   // Register indexes (byte address is four times the index)
   typedef enum logic [2:0] {
      REG_RESOLUTION   = 3'd0,
      REG_FILTER_ALPHA = 3'd1,
      REG_GAIN_P       = 3'd2,
      REG_GAIN_I       = 3'd3,
      REG_GAIN_D       = 3'd4,
      REG_TICK_PERIOD  = 3'd5,
      REG_TICK_RATE    = 3'd6
   } reg_index_type;

   // Reset values
   localparam logic [CFG_W-1:0] RST_RESOLUTION   = 16'd1577;
   localparam logic [CFG_W-1:0] RST_FILTER_ALPHA = 16'd3277;
   localparam logic [CFG_W-1:0] RST_GAIN_P       = 16'd717;
   localparam logic [CFG_W-1:0] RST_GAIN_I       = 16'd15;
   localparam logic [CFG_W-1:0] RST_GAIN_D       = 16'd102;
   localparam logic [CFG_W-1:0] RST_TICK_PERIOD  = 16'd131;
   localparam logic [CFG_W-1:0] RST_TICK_RATE    = 16'd500;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [CFG_W-1:0] resolution;
      logic [CFG_W-1:0] filter_alpha;
      logic [CFG_W-1:0] gain_p;
      logic [CFG_W-1:0] gain_i;
      logic [CFG_W-1:0] gain_d;
      logic [CFG_W-1:0] tick_period;
      logic [CFG_W-1:0] tick_rate;
   } cfg_type;

endpackage

// ===== sv/ecpd_csr.sv =====
// ecpd_csr: APB-style register file for the controller settings.
// Depends on ecpd_pkg for the register indexes, reset values and cfg_type.
module ecpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ecpd_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [ecpd_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [ecpd_pkg::DATA_W-1:0]    csr_prdata,
   output logic                           csr_pready,
   output ecpd_pkg::cfg_type              cfg
);

   ecpd_pkg::cfg_type       cfg_ff;
   ecpd_pkg::reg_index_type index;
   logic                    wr_en;
   logic [ecpd_pkg::CFG_W-1:0] rd_val;

   assign index      = ecpd_pkg::reg_index_type'(csr_paddr[ecpd_pkg::ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // Write the addressed register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resolution   <= ecpd_pkg::RST_RESOLUTION;
         cfg_ff.filter_alpha <= ecpd_pkg::RST_FILTER_ALPHA;
         cfg_ff.gain_p       <= ecpd_pkg::RST_GAIN_P;
         cfg_ff.gain_i       <= ecpd_pkg::RST_GAIN_I;
         cfg_ff.gain_d       <= ecpd_pkg::RST_GAIN_D;
         cfg_ff.tick_period  <= ecpd_pkg::RST_TICK_PERIOD;
         cfg_ff.tick_rate    <= ecpd_pkg::RST_TICK_RATE;
      end else if (wr_en) begin
         case (index)
            ecpd_pkg::REG_RESOLUTION:   cfg_ff.resolution   <= csr_pwdata[15:0];
            ecpd_pkg::REG_FILTER_ALPHA: cfg_ff.filter_alpha <= csr_pwdata[15:0];
            ecpd_pkg::REG_GAIN_P:       cfg_ff.gain_p       <= csr_pwdata[15:0];
            ecpd_pkg::REG_GAIN_I:       cfg_ff.gain_i       <= csr_pwdata[15:0];
            ecpd_pkg::REG_GAIN_D:       cfg_ff.gain_d       <= csr_pwdata[15:0];
            ecpd_pkg::REG_TICK_PERIOD:  cfg_ff.tick_period  <= csr_pwdata[15:0];
            ecpd_pkg::REG_TICK_RATE:    cfg_ff.tick_rate    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read mux; unused addresses read zero
   always_comb begin
      case (index)
         ecpd_pkg::REG_RESOLUTION:   rd_val = cfg_ff.resolution;
         ecpd_pkg::REG_FILTER_ALPHA: rd_val = cfg_ff.filter_alpha;
         ecpd_pkg::REG_GAIN_P:       rd_val = cfg_ff.gain_p;
         ecpd_pkg::REG_GAIN_I:       rd_val = cfg_ff.gain_i;
         ecpd_pkg::REG_GAIN_D:       rd_val = cfg_ff.gain_d;
         ecpd_pkg::REG_TICK_PERIOD:  rd_val = cfg_ff.tick_period;
         ecpd_pkg::REG_TICK_RATE:    rd_val = cfg_ff.tick_rate;
         default:                    rd_val = '0;
      endcase
   end

   assign csr_prdata = ecpd_pkg::DATA_W'(rd_val);

endmodule

// ===== sv/ecpd_front.sv =====
// ecpd_front: accepts items, keeps the saturating edge count, queues ticks.
// Depends on ecpd_pkg for command codes and widths.
module ecpd_front #(
   parameter int COUNT_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [ecpd_pkg::CMD_W-1:0]                req_command,
   input  logic                                      req_other_level,
   input  logic signed [ecpd_pkg::POS_W-1:0]         req_target,
   input  logic                                      q_full,
   output logic                                      q_push,
   output logic [ecpd_pkg::POS_W+COUNT_BITS-1:0]     q_data
);

   localparam logic signed [COUNT_BITS-1:0] CountMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] CountMin = {1'b1, {(COUNT_BITS-1){1'b0}}};

   logic signed [COUNT_BITS-1:0] count_ff;
   logic signed [COUNT_BITS-1:0] count_in;
   logic                         accept;
   logic                         step_up;
   logic                         step_down;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify the item: count step, tick, or drop
   always_comb begin
      step_up   = 1'b0;
      step_down = 1'b0;
      q_push    = 1'b0;
      case (req_command)
         ecpd_pkg::CMD_EDGE_A: begin
            step_up   = accept && !req_other_level;
            step_down = accept &&  req_other_level;
         end
         ecpd_pkg::CMD_EDGE_B: begin
            step_up   = accept &&  req_other_level;
            step_down = accept && !req_other_level;
         end
         ecpd_pkg::CMD_TICK: begin
            q_push = accept;
         end
         default: ;
      endcase
   end

   // Saturate the count at both ends of its range
   always_comb begin
      count_in = count_ff;
      if (step_up && count_ff != CountMax) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (step_down && count_ff != CountMin) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A tick carries the count as it stands when the tick arrives
   assign q_data = {req_target, count_ff};

   a_up_never_min: assert property (@(posedge clock) disable iff (reset)
      step_up |=> count_ff != CountMin)
      else $error("edge count wrapped on an up step");

endmodule

// ===== sv/ecpd_queue.sv =====
// ecpd_queue: two-entry queue of tick items between front and back.
// Depends on ecpd_pkg only through the width its users pass in.
module ecpd_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             not_empty,
   output logic             full
);

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);

   logic [WIDTH-1:0] entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [PtrW:0]    fill_ff;

   assign full      = fill_ff == (PtrW+1)'(Depth);
   assign not_empty = fill_ff != '0;
   assign head_data = entry_ff[rd_ptr_ff];

   // Store on push
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + (PtrW+1)'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - (PtrW+1)'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("tick queue written while full");

endmodule

// ===== sv/ecpd_back.sv =====
// ecpd_back: tick sequencer with one shared registered multiplier.
// Forms position, filtered velocity, integrator and clamped PID drive.
// Depends on ecpd_pkg for widths and cfg_type.
module ecpd_back #(
   parameter int COUNT_BITS    = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ecpd_pkg::cfg_type                         cfg,
   input  logic                                      q_not_empty,
   input  logic [ecpd_pkg::POS_W+COUNT_BITS-1:0]     q_data,
   output logic                                      q_pop,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [ecpd_pkg::DUTY_W-1:0]               rsp_duty,
   output logic                                      rsp_forward,
   output logic signed [ecpd_pkg::POS_W-1:0]         rsp_position
);

   localparam int PW   = ecpd_pkg::POS_W;
   localparam int DW   = ecpd_pkg::DIFF_W;
   localparam int VW   = ecpd_pkg::VEL_W;
   localparam int AW   = ecpd_pkg::MUL_A_W;
   localparam int BW   = ecpd_pkg::MUL_B_W;
   localparam int RW   = ecpd_pkg::PROD_W;
   localparam int CW   = ecpd_pkg::ACC_W;
   localparam int UpShift = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
   localparam int DnShift = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
   localparam int SW   = RW + 8;             // room for the largest up shift
   localparam int IW   = RW - 16 + 1;        // integrator sum width
   localparam int HW   = CW - 8;             // drive before clamping
   localparam int DRV_W = FRACTION_BITS + 5; // holds +-12.0
   localparam int MAG_W = DRV_W + 7;         // magnitude times 85
   localparam logic signed [HW-1:0] DriveLim = HW'(12) <<< FRACTION_BITS;
   localparam logic signed [HW-1:0] DriveNeg = -DriveLim;
   localparam logic signed [PW-1:0] PosMax = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] PosMin = {1'b1, {(PW-1){1'b0}}};
   localparam logic signed [VW-1:0] VelMax = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VelMin = {1'b1, {(VW-1){1'b0}}};

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_POS   = 14'b00000000000010,
      ST_SAT   = 14'b00000000000100,
      ST_DIFF  = 14'b00000000001000,
      ST_RAW   = 14'b00000000010000,
      ST_VA    = 14'b00000000100000,
      ST_VB    = 14'b00000001000000,
      ST_VC    = 14'b00000010000000,
      ST_INT   = 14'b00000100000000,
      ST_PD    = 14'b00001000000000,
      ST_PI    = 14'b00010000000000,
      ST_SUM   = 14'b00100000000000,
      ST_DRIVE = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic signed [PW-1:0]      target_ff;
   logic signed [COUNT_BITS-1:0] count_ff;
   logic signed [RW-1:0]      prod_ff;
   logic signed [CW-1:0]      acc_ff;
   logic signed [PW-1:0]      pos_ff;
   logic signed [PW-1:0]      last_ff;
   logic signed [DW-1:0]      diff_ff;
   logic signed [DW-1:0]      err_ff;
   logic signed [VW-1:0]      raw_ff;
   logic signed [VW-1:0]      vel_ff;
   logic signed [VW-1:0]      integ_ff;
   logic signed [DRV_W-1:0]   drive_ff;
   logic                      rsp_valid_ff;
   logic [ecpd_pkg::DUTY_W-1:0] rsp_duty_ff;
   logic                      rsp_forward_ff;
   logic signed [PW-1:0]      rsp_position_ff;

   logic signed [AW-1:0]      mul_a;
   logic signed [BW-1:0]      mul_b;
   logic signed [SW-1:0]      prod_ext;
   logic signed [SW-1:0]      scaled;
   logic signed [PW-1:0]      pos_sat;
   logic signed [VW-1:0]      raw_sat;
   logic signed [CW-1:0]      vel_sum;
   logic signed [IW-1:0]      integ_sum;
   logic signed [VW-1:0]      integ_sat;
   logic signed [HW-1:0]      drive_pre;
   logic signed [HW-1:0]      drive_clamp;
   logic [DRV_W-1:0]          drive_mag;
   logic [MAG_W-1:0]          mag85;
   logic [MAG_W-FRACTION_BITS-3:0] duty_wide;
   logic [ecpd_pkg::DUTY_W-1:0] duty;
   logic                      out_load;

   // Pick multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_POS: begin
            mul_a = {2'b00, cfg.resolution};
            mul_b = BW'(count_ff);
         end
         ST_RAW: begin
            mul_a = {2'b00, cfg.tick_rate};
            mul_b = BW'(diff_ff);
         end
         ST_VA: begin
            mul_a = AW'(18'h10000 - {2'b00, cfg.filter_alpha});
            mul_b = BW'(vel_ff);
         end
         ST_VB: begin
            mul_a = {2'b00, cfg.filter_alpha};
            mul_b = BW'(raw_ff);
         end
         ST_VC: begin
            mul_a = {2'b00, cfg.tick_period};
            mul_b = BW'(err_ff);
         end
         ST_INT: begin
            mul_a = {2'b00, cfg.gain_p};
            mul_b = BW'(err_ff);
         end
         ST_PD: begin
            mul_a = {2'b00, cfg.gain_d};
            mul_b = BW'(vel_ff);
         end
         ST_PI: begin
            mul_a = {2'b00, cfg.gain_i};
            mul_b = BW'(integ_ff);
         end
         default: ;
      endcase
   end

   // Shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Rescale count product to the position format and saturate
   assign prod_ext = SW'(prod_ff);
   assign scaled   = (prod_ext <<< UpShift) >>> DnShift;
   always_comb begin
      if ((&scaled[SW-1:PW-1]) || !(|scaled[SW-1:PW-1])) begin
         pos_sat = scaled[PW-1:0];
      end else begin
         pos_sat = scaled[SW-1] ? PosMin : PosMax;
      end
   end

   // Saturate the raw velocity
   always_comb begin
      if ((&prod_ff[RW-1:VW-1]) || !(|prod_ff[RW-1:VW-1])) begin
         raw_sat = prod_ff[VW-1:0];
      end else begin
         raw_sat = prod_ff[RW-1] ? VelMin : VelMax;
      end
   end

   // Blend old and new velocity
   assign vel_sum = acc_ff + CW'(prod_ff);

   // Integrate the scaled error and saturate
   assign integ_sum = IW'(integ_ff) + IW'($signed(prod_ff[RW-1:16]));
   always_comb begin
      if ((&integ_sum[IW-1:VW-1]) || !(|integ_sum[IW-1:VW-1])) begin
         integ_sat = integ_sum[VW-1:0];
      end else begin
         integ_sat = integ_sum[IW-1] ? VelMin : VelMax;
      end
   end

   // Floor the drive sum to the position format and clamp
   assign drive_pre = $signed(acc_ff[CW-1:8]);
   always_comb begin
      if (drive_pre > DriveLim) begin
         drive_clamp = DriveLim;
      end else if (drive_pre < DriveNeg) begin
         drive_clamp = DriveNeg;
      end else begin
         drive_clamp = drive_pre;
      end
   end

   // Scale the magnitude by 21.25 and cap the duty
   assign drive_mag = drive_ff[DRV_W-1] ? DRV_W'(-drive_ff) : DRV_W'(drive_ff);
   assign mag85     = MAG_W'(drive_mag) * MAG_W'(85);
   assign duty_wide = mag85[MAG_W-1:FRACTION_BITS+2];
   assign duty      = (duty_wide > (MAG_W-FRACTION_BITS-2)'(255)) ?
                      ecpd_pkg::DUTY_W'(255) : duty_wide[ecpd_pkg::DUTY_W-1:0];

   assign q_pop    = (state_ff == ST_IDLE) && q_not_empty;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Step through the tick sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (q_not_empty) state_in = ST_POS;
         ST_POS:   state_in = ST_SAT;
         ST_SAT:   state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_RAW;
         ST_RAW:   state_in = ST_VA;
         ST_VA:    state_in = ST_VB;
         ST_VB:    state_in = ST_VC;
         ST_VC:    state_in = ST_INT;
         ST_INT:   state_in = ST_PD;
         ST_PD:    state_in = ST_PI;
         ST_PI:    state_in = ST_SUM;
         ST_SUM:   state_in = ST_DRIVE;
         ST_DRIVE: state_in = ST_OUT;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= '0;
         vel_ff   <= '0;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DIFF) begin
            last_ff <= pos_ff;
         end
         if (state_ff == ST_VC) begin
            vel_ff <= vel_sum[VW+15:16];
         end
         if (state_ff == ST_INT) begin
            integ_ff <= integ_sat;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            target_ff <= $signed(q_data[PW+COUNT_BITS-1:COUNT_BITS]);
            count_ff  <= $signed(q_data[COUNT_BITS-1:0]);
         end
         ST_SAT:   pos_ff  <= pos_sat;
         ST_DIFF: begin
            diff_ff <= DW'(pos_ff) - DW'(last_ff);
            err_ff  <= DW'(target_ff) - DW'(pos_ff);
         end
         ST_VA:    raw_ff  <= raw_sat;
         ST_VB:    acc_ff  <= CW'(prod_ff);
         ST_PD:    acc_ff  <= CW'(prod_ff);
         ST_PI:    acc_ff  <= acc_ff - CW'(prod_ff);
         ST_SUM:   acc_ff  <= acc_ff + CW'(prod_ff);
         ST_DRIVE: drive_ff <= DRV_W'(drive_clamp);
         default: ;
      endcase
   end

   // Output register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_duty_ff     <= duty;
         rsp_forward_ff  <= !drive_ff[DRV_W-1] && (drive_ff != '0);
         rsp_position_ff <= pos_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_duty     = rsp_duty_ff;
   assign rsp_forward  = rsp_forward_ff;
   assign rsp_position = rsp_position_ff;

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result appeared without the output step");

   a_wait_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_OUT)
      else $error("sequencer left output step while result was stalled");

   a_drive_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> (HW'(drive_ff) <= DriveLim && HW'(drive_ff) >= DriveNeg))
      else $error("drive outside clamp limits");

endmodule

// ===== sv/encoder_pid_motor_drive.sv =====
// encoder_pid_motor_drive: quadrature encoder count plus PID position drive.
// Top level; instantiates ecpd_csr, ecpd_front, ecpd_queue and ecpd_back.
//
// Usage:
//  - req channel: each item is an encoder edge (A or B rising, with the level
//    of the other channel) or a control tick carrying a position target.
//    Edge items update the count in the cycle they are accepted and give no
//    result; unused command codes are dropped.
//  - rsp channel: each tick gives one item with duty (0..255), forward and
//    the position used for that tick.
//  - csr port: seven 16-bit settings at byte address 4*index; write only
//    while no tick is in flight.
// Timing: each accepted tick waits in the tick queue; the back end then steps
// it from position through drive to the output step, which registers the result.
// Ticks are worked one at a time; one shared 18x49 multiplier walks eight products.
// Edge items are taken every cycle while the two-entry tick queue has room.
// Reset clears the count, the velocity filter, the integrator and the last
// position, and loads the default settings. When rsp_stall is high the
// result holds, the back end waits, and once the queue fills req_stall rises.
module encoder_pid_motor_drive #(
   parameter int COUNT_BITS    = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ecpd_pkg::CMD_W-1:0]          req_command,
   input  logic                                req_other_level,
   input  logic signed [ecpd_pkg::POS_W-1:0]   req_target,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ecpd_pkg::DUTY_W-1:0]         rsp_duty,
   output logic                                rsp_forward,
   output logic signed [ecpd_pkg::POS_W-1:0]   rsp_position,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ecpd_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [ecpd_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [ecpd_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);

   localparam int QW = ecpd_pkg::POS_W + COUNT_BITS;

   ecpd_pkg::cfg_type cfg;
   logic              q_push;
   logic [QW-1:0]     q_push_data;
   logic              q_pop;
   logic [QW-1:0]     q_head;
   logic              q_not_empty;
   logic              q_full;

   ecpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ecpd_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_other_level (req_other_level),
      .req_target      (req_target),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   ecpd_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   ecpd_back #(
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_not_empty  (q_not_empty),
      .q_data       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_duty     (rsp_duty),
      .rsp_forward  (rsp_forward),
      .rsp_position (rsp_position)
   );

endmodule

// ===== tb/encoder_pid_motor_drive_test.sv =====
// encoder_pid_motor_drive_test: self-checking testbench for the encoder PID motor drive.
// Sends edge and tick items, programs and reads back the csr port, and checks every drive result
// against a fixed-point predictor or directed rows. Depends on ecpd_pkg and encoder_pid_motor_drive.
module encoder_pid_motor_drive_test;

   localparam int COUNT_BITS    = 24;
   localparam int FRACTION_BITS = 16;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 30;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 20;
   localparam int WINDUP_UP     = 270;
   localparam int WINDUP_TICKS  = 300;
   localparam int EDGE_RUN      = 12;

   localparam int CMD_W  = ecpd_pkg::CMD_W;
   localparam int POS_W  = ecpd_pkg::POS_W;
   localparam int VEL_W  = ecpd_pkg::VEL_W;
   localparam int CFG_W  = ecpd_pkg::CFG_W;
   localparam int DUTY_W = ecpd_pkg::DUTY_W;
   localparam int ADDR_W = ecpd_pkg::ADDR_W;
   localparam int DATA_W = ecpd_pkg::DATA_W;

   localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
   localparam logic signed [POS_W-1:0] TARGET_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] TARGET_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [CFG_W-1:0]        CFG_MAX    = {CFG_W{1'b1}};
   localparam logic [CFG_W-1:0]        CFG_ZERO   = {CFG_W{1'b0}};

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [DUTY_W-1:0]       duty;
      logic                    forward;
      logic signed [POS_W-1:0] position;
   } drive_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic                    other;
      logic signed [POS_W-1:0] target;
      logic                    typed;
      drive_result_type        want;
   } stim_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_command = ecpd_pkg::CMD_EDGE_A;
   logic                    req_other_level = 1'b0;
   logic signed [POS_W-1:0] req_target = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DUTY_W-1:0]       rsp_duty;
   logic                    rsp_forward;
   logic signed [POS_W-1:0] rsp_position;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]       csr_paddr = '0;
   logic [DATA_W-1:0]       csr_pwdata = '0;
   logic [DATA_W-1:0]       csr_prdata;
   logic                    csr_pready;

   // Predictor copy of the settings and the controller state
   logic [CFG_W-1:0]  cfg_shadow [0:6];
   wide_type          edge_total = '0;
   wide_type          last_pos = '0;
   wide_type          vel_smooth = '0;
   wide_type          integ_sum = '0;
   drive_result_type  pending_drive [$];

   int          mismatches = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          gappy = 1'b1;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;

   encoder_pid_motor_drive #(
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_other_level (req_other_level),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_duty        (rsp_duty),
      .rsp_forward     (rsp_forward),
      .rsp_position    (rsp_position),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   // Saturate to a signed field of w bits
   function automatic wide_type clip(wide_type x, int w);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic wide_type cfg_val(ecpd_pkg::reg_index_type idx);
      return wide_type'(cfg_shadow[idx]);
   endfunction

   // Move the saturating edge count by one
   function automatic void count_edge(logic [CMD_W-1:0] cmd, logic other);
      logic up;
      up = (cmd == ecpd_pkg::CMD_EDGE_A) ? !other : other;
      if (up) edge_total = clip(edge_total + 1, COUNT_BITS);
      else edge_total = clip(edge_total - 1, COUNT_BITS);
   endfunction

   // Work out one control tick: position, filtered velocity, integrator and drive
   function automatic drive_result_type tick_drive(logic signed [POS_W-1:0] target);
      wide_type pos, raw, alpha, err, drive, lim, mag, duty;
      drive_result_type r;
      pos = cfg_val(ecpd_pkg::REG_RESOLUTION) * edge_total;
      if (FRACTION_BITS >= 16) pos = pos <<< (FRACTION_BITS - 16);
      else pos = pos >>> (16 - FRACTION_BITS);
      pos = clip(pos, POS_W);
      raw = clip((pos - last_pos) * cfg_val(ecpd_pkg::REG_TICK_RATE), VEL_W);
      alpha = cfg_val(ecpd_pkg::REG_FILTER_ALPHA);
      vel_smooth = (alpha * raw + (wide_type'(65536) - alpha) * vel_smooth) >>> 16;
      err = wide_type'(target) - pos;
      integ_sum = clip(integ_sum + ((err * cfg_val(ecpd_pkg::REG_TICK_PERIOD)) >>> 16),
                       VEL_W);
      // floor of the exact three-term sum
      drive = (cfg_val(ecpd_pkg::REG_GAIN_P) * err
               - cfg_val(ecpd_pkg::REG_GAIN_D) * vel_smooth
               + cfg_val(ecpd_pkg::REG_GAIN_I) * integ_sum) >>> 8;
      lim = wide_type'(12) <<< FRACTION_BITS;
      if (drive > lim) drive = lim;
      if (drive < -lim) drive = -lim;
      mag = (drive < 0) ? -drive : drive;
      duty = (mag * 85) >>> (FRACTION_BITS + 2);
      if (duty > 255) duty = 255;
      last_pos = pos;
      r.duty = duty[DUTY_W-1:0];
      r.forward = (drive > 0);
      r.position = pos[POS_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type make_row(logic [CMD_W-1:0] cmd, logic other,
                                             logic signed [POS_W-1:0] target,
                                             logic typed = 1'b0,
                                             logic [DUTY_W-1:0] duty = '0,
                                             logic fwd = 1'b0,
                                             logic signed [POS_W-1:0] pos = '0);
      stim_row_type s;
      s.cmd = cmd;
      s.other = other;
      s.target = target;
      s.typed = typed;
      s.want.duty = duty;
      s.want.forward = fwd;
      s.want.position = pos;
      return s;
   endfunction

   function automatic logic [CFG_W-1:0] rand_cfg(int unsigned hi);
      return CFG_W'($urandom_range(0, hi));
   endfunction

   // Half the targets near the current position, the rest extremes and full-range noise
   function automatic logic signed [POS_W-1:0] random_target();
      logic [63:0] bits;
      wide_type near;
      bits = {$urandom(), $urandom()};
      near = clip(last_pos + wide_type'($urandom_range(0, 2097152)) - wide_type'(1048576),
                  POS_W);
      case ($urandom_range(0, 7))
         0: return TARGET_MAX;
         1: return TARGET_MIN;
         2, 3: return bits[POS_W-1:0];
         default: return near[POS_W-1:0];
      endcase
   endfunction

   function automatic stim_row_type random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return make_row(CMD_UNUSED, 1'($urandom_range(0, 1)), random_target());
      if (pick < 60) begin
         return make_row($urandom_range(0, 1) ? ecpd_pkg::CMD_EDGE_B : ecpd_pkg::CMD_EDGE_A,
                         1'($urandom_range(0, 1)), random_target());
      end
      return make_row(ecpd_pkg::CMD_TICK, 1'($urandom_range(0, 1)), random_target());
   endfunction

   // Present one item, hold it until taken, then update the predictor
   task automatic send(stim_row_type row);
      drive_result_type got;
      req_valid <= 1'b1;
      req_command <= row.cmd;
      req_other_level <= row.other;
      req_target <= row.target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (row.cmd)
         ecpd_pkg::CMD_EDGE_A, ecpd_pkg::CMD_EDGE_B: count_edge(row.cmd, row.other);
         ecpd_pkg::CMD_TICK: begin
            got = tick_drive(row.target);
            pending_drive.push_back(row.typed ? row.want : got);
         end
         default: ;   // unused code: dropped by the block
      endcase
   endtask

   // Hold valid low until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_drive.size() != 0);
   endtask

   task automatic quiesce();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Insert a random gap between bursts, now and then draining the block
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 16);
      if (!gappy) return;
      if ($urandom_range(0, 29) == 0) begin
         drain();
         return;
      end
      gap = $urandom_range(0, 8);
      if (gap == 0) return;
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic csr_write(ecpd_pkg::reg_index_type idx, logic [CFG_W-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {{(DATA_W-CFG_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cfg_shadow[idx] = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(ecpd_pkg::reg_index_type idx);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {{(DATA_W-CFG_W){1'b0}}, cfg_shadow[idx]}) begin
         note_mismatch($sformatf("register %s read %0h, expected %0h",
                                 idx.name(), csr_prdata, cfg_shadow[idx]));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write every register while idle, then read them all back
   task automatic set_config(logic [CFG_W-1:0] res, logic [CFG_W-1:0] alpha,
                             logic [CFG_W-1:0] kp, logic [CFG_W-1:0] ki,
                             logic [CFG_W-1:0] kd, logic [CFG_W-1:0] period,
                             logic [CFG_W-1:0] rate);
      quiesce();
      csr_write(ecpd_pkg::REG_RESOLUTION, res);
      csr_write(ecpd_pkg::REG_FILTER_ALPHA, alpha);
      csr_write(ecpd_pkg::REG_GAIN_P, kp);
      csr_write(ecpd_pkg::REG_GAIN_I, ki);
      csr_write(ecpd_pkg::REG_GAIN_D, kd);
      csr_write(ecpd_pkg::REG_TICK_PERIOD, period);
      csr_write(ecpd_pkg::REG_TICK_RATE, rate);
      for (int i = 0; i < 7; i++) csr_check(ecpd_pkg::reg_index_type'(i));
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stall the result channel on a mode that changes at random intervals
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_stall <= 1'b0;
         RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((cycle_count % 7) < 3);
      endcase
   end

   // Compare each taken result with the oldest expectation
   always @(posedge clock) begin : drive_checker
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            note_mismatch($sformatf("unexpected item: duty %0d forward %0d position %0d",
                                    rsp_duty, rsp_forward, rsp_position));
         end else begin
            want = pending_drive.pop_front();
            if (rsp_duty !== want.duty || rsp_forward !== want.forward
                || rsp_position !== want.position) begin
               note_mismatch($sformatf(
                  "duty %0d/%0d forward %0d/%0d position %0d/%0d (expected/actual)",
                  want.duty, rsp_duty, want.forward, rsp_forward,
                  want.position, rsp_position));
            end
         end
      end
   end

   initial begin
      stim_row_type plan [$];
      int k;
      logic narrow;

      cfg_shadow[ecpd_pkg::REG_RESOLUTION] = ecpd_pkg::RST_RESOLUTION;
      cfg_shadow[ecpd_pkg::REG_FILTER_ALPHA] = ecpd_pkg::RST_FILTER_ALPHA;
      cfg_shadow[ecpd_pkg::REG_GAIN_P] = ecpd_pkg::RST_GAIN_P;
      cfg_shadow[ecpd_pkg::REG_GAIN_I] = ecpd_pkg::RST_GAIN_I;
      cfg_shadow[ecpd_pkg::REG_GAIN_D] = ecpd_pkg::RST_GAIN_D;
      cfg_shadow[ecpd_pkg::REG_TICK_PERIOD] = ecpd_pkg::RST_TICK_PERIOD;
      cfg_shadow[ecpd_pkg::REG_TICK_RATE] = ecpd_pkg::RST_TICK_RATE;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset values read back
      for (int i = 0; i < 7; i++) csr_check(ecpd_pkg::reg_index_type'(i));

      // Directed rows: zero tick, extreme targets, floor of a tiny negative drive,
      // every edge direction, unused command codes
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b0, 40'sd0, 1'b1, 8'd0, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b0, TARGET_MAX, 1'b1, 8'd255, 1'b1,
                              40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b1, TARGET_MIN, 1'b1, 8'd255, 1'b0,
                              40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b0, 40'sd0, 1'b1, 8'd0, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_A, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_A, 1'b1, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_B, 1'b1, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_B, 1'b0, 40'sd0));
      plan.push_back(make_row(CMD_UNUSED, 1'b1, TARGET_MAX));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_A, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_A, 1'b0, TARGET_MIN));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_A, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b1, 40'sd4731));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_B, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_EDGE_B, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b0, -40'sd1));
      plan.push_back(make_row(CMD_UNUSED, 1'b0, 40'sd0));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b0, 40'sh00_0001_0000));
      plan.push_back(make_row(ecpd_pkg::CMD_TICK, 1'b1, TARGET_MAX));
      foreach (plan[i]) begin
         pace();
         send(plan[i]);
      end

      // Wind the integrator into its upper limit, then pull it back
      gappy = 1'b1;
      set_config(ecpd_pkg::RST_RESOLUTION, ecpd_pkg::RST_FILTER_ALPHA, CFG_ZERO, CFG_MAX,
                 CFG_ZERO, CFG_MAX, ecpd_pkg::RST_TICK_RATE);
      for (k = 0; k < WINDUP_TICKS; k++) begin
         pace();
         send(make_row(ecpd_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                       (k < WINDUP_UP) ? TARGET_MAX : TARGET_MIN));
      end

      // Random phases under different settings: all ones, all zero, reset, then random
      for (int p = 0; p < 8; p++) begin
         narrow = p[0];
         case (p)
            0: set_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
            1: set_config(CFG_ZERO, CFG_ZERO, CFG_ZERO, CFG_ZERO, CFG_ZERO, CFG_ZERO,
                          CFG_ZERO);
            2: set_config(ecpd_pkg::RST_RESOLUTION, ecpd_pkg::RST_FILTER_ALPHA,
                          ecpd_pkg::RST_GAIN_P, ecpd_pkg::RST_GAIN_I, ecpd_pkg::RST_GAIN_D,
                          ecpd_pkg::RST_TICK_PERIOD, ecpd_pkg::RST_TICK_RATE);
            default: set_config(rand_cfg(65535), rand_cfg(65535),
                                rand_cfg(narrow ? 1023 : 65535),
                                rand_cfg(narrow ? 63 : 65535),
                                rand_cfg(narrow ? 255 : 65535), rand_cfg(65535),
                                rand_cfg(narrow ? 1000 : 65535));
         endcase
         gappy = (p % 3) != 0;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            pace();
            send(random_item());
         end
      end

      // Run the count up, then jump the resolution between ticks
      gappy = 1'b1;
      set_config(CFG_ZERO, CFG_MAX, ecpd_pkg::RST_GAIN_P, ecpd_pkg::RST_GAIN_I,
                 ecpd_pkg::RST_GAIN_D, ecpd_pkg::RST_TICK_PERIOD, CFG_MAX);
      gappy = 1'b0;
      for (k = 0; k < EDGE_RUN; k++) send(make_row(ecpd_pkg::CMD_EDGE_A, 1'b0, 40'sd0));
      send(make_row(ecpd_pkg::CMD_TICK, 1'b0, 40'sd0));
      quiesce();
      csr_write(ecpd_pkg::REG_RESOLUTION, CFG_MAX);
      send(make_row(ecpd_pkg::CMD_TICK, 1'b0, TARGET_MAX));
      quiesce();
      csr_write(ecpd_pkg::REG_RESOLUTION, CFG_ZERO);
      send(make_row(ecpd_pkg::CMD_TICK, 1'b0, TARGET_MIN));
      for (k = 0; k < EDGE_RUN; k++) send(make_row(ecpd_pkg::CMD_EDGE_B, 1'b0, 40'sd0));
      send(make_row(ecpd_pkg::CMD_TICK, 1'b1, 40'sd0));

      // Close with reset settings and random traffic
      gappy = 1'b1;
      set_config(ecpd_pkg::RST_RESOLUTION, ecpd_pkg::RST_FILTER_ALPHA, ecpd_pkg::RST_GAIN_P,
                 ecpd_pkg::RST_GAIN_I, ecpd_pkg::RST_GAIN_D, ecpd_pkg::RST_TICK_PERIOD,
                 ecpd_pkg::RST_TICK_RATE);
      for (k = 0; k < PHASE_ITEMS; k++) begin
         pace();
         send(random_item());
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_drive.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
